@@ hw/rtl/top_k_result_selector_core_defines.svh @@
// ----------------------------------------------------------------------------
// top-k result selector assertion macros
// shared concurrent assertion wrappers, empty when SYNTH is defined
// ----------------------------------------------------------------------------
`ifndef TOP_K_RESULT_SELECTOR_CORE_DEFINES_SVH
`define TOP_K_RESULT_SELECTOR_CORE_DEFINES_SVH

`ifndef SYNTH
// same-cycle implication
`define TKS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tks assertion failed");
// next-cycle implication
`define TKS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tks assertion failed");
`else
`define TKS_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define TKS_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

@@ hw/rtl/tks_pkg.sv @@
// ----------------------------------------------------------------------------
// top-k selector package
// entry layout, control types, ranking function and fixed field widths
// ----------------------------------------------------------------------------
package tks_pkg;

    localparam int COORD_W    = 32;
    localparam int COUNT_W    = 8;
    localparam int DIST_W     = 64;
    localparam int HITS_W     = 64;
    localparam int RANK_W     = 5;
    localparam int LIMIT_W    = 6;
    localparam int IN_DATA_W  = 72;
    localparam int OUT_DATA_W = 144;
    localparam int OUT_PAD_W  = OUT_DATA_W - (RANK_W + 2 * COORD_W + COUNT_W + HITS_W);

    localparam logic [LIMIT_W-1:0] KEEP_LIMIT_RST = 6'd32;

    // operation codes carried on the input tuser
    localparam logic OP_ADD    = 1'b0;
    localparam logic OP_FINISH = 1'b1;

    // one kept hit, with its squared distance stored alongside
    typedef struct packed {
        logic [COUNT_W-1:0]        hit_count;
        logic [DIST_W-1:0]         dist_sq;
        logic signed [COORD_W-1:0] coord_x;
        logic signed [COORD_W-1:0] coord_z;
    } t_entry;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SQ_X,
        S_SQ_Z,
        S_SUM,
        S_ADD_CHK,
        S_SCAN,
        S_REPLACE,
        S_SORT_INIT,
        S_SORT_SCAN,
        S_EMIT,
        S_EMPTY
    } t_ctl_state;

    typedef struct packed {
        logic accept_add;
        logic accept_fin;
        logic sq_x;
        logic sq_z;
        logic sum;
        logic append;
        logic scan_start;
        logic scan_run;
        logic sort;
        logic replace;
        logic emit;
        logic emit_empty;
    } t_dp_cmd;

    typedef struct packed {
        logic kept_zero;
        logic room;
        logic scan_done;
        logic out_free;
        logic emit_last;
    } t_dp_status;

    // true when a ranks strictly before b
    function automatic logic f_better(input t_entry a, input t_entry b);
        logic res;
        if (a.hit_count != b.hit_count) begin
            res = a.hit_count > b.hit_count;
        end else if (a.dist_sq != b.dist_sq) begin
            res = a.dist_sq < b.dist_sq;
        end else if (a.coord_x != b.coord_x) begin
            res = $signed(a.coord_x) < $signed(b.coord_x);
        end else begin
            res = $signed(a.coord_z) < $signed(b.coord_z);
        end
        return res;
    endfunction

endpackage

@@ hw/rtl/tks_ctrl.sv @@
// ----------------------------------------------------------------------------
// top-k selector controller
// sequences distance, worst-entry walk, replacement and selection sort
// ----------------------------------------------------------------------------
module tks_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic                i_in_op,
    output logic                o_in_ready,
    input  tks_pkg::t_dp_status i_status,
    output tks_pkg::t_dp_cmd    o_cmd
);
    import tks_pkg::*;

    t_ctl_state r_state;
    t_ctl_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    if (i_in_op == OP_FINISH) begin
                        n_state = i_status.kept_zero ? S_EMPTY : S_SORT_INIT;
                    end else begin
                        n_state = S_SQ_X;
                    end
                end
            end
            S_SQ_X:    n_state = S_SQ_Z;
            S_SQ_Z:    n_state = S_SUM;
            S_SUM:     n_state = S_ADD_CHK;
            S_ADD_CHK: begin
                if (i_status.room || i_status.kept_zero) begin
                    n_state = S_IDLE;
                end else begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (i_status.scan_done) begin
                    n_state = S_REPLACE;
                end
            end
            S_REPLACE:   n_state = S_IDLE;
            S_SORT_INIT: n_state = S_SORT_SCAN;
            S_SORT_SCAN: begin
                if (i_status.scan_done) begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (i_status.out_free) begin
                    n_state = i_status.emit_last ? S_IDLE : S_SORT_INIT;
                end
            end
            S_EMPTY: begin
                if (i_status.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready       = 1'b1;
                o_cmd.accept_add = i_in_valid && (i_in_op == OP_ADD);
                o_cmd.accept_fin = i_in_valid && (i_in_op == OP_FINISH);
            end
            S_SQ_X:  o_cmd.sq_x = 1'b1;
            S_SQ_Z:  o_cmd.sq_z = 1'b1;
            S_SUM:   o_cmd.sum  = 1'b1;
            S_ADD_CHK: begin
                o_cmd.append     = 1'b1;
                o_cmd.scan_start = 1'b1;
            end
            S_SCAN:    o_cmd.scan_run = 1'b1;
            S_REPLACE: o_cmd.replace  = 1'b1;
            S_SORT_INIT: begin
                o_cmd.sort       = 1'b1;
                o_cmd.scan_start = 1'b1;
            end
            S_SORT_SCAN: begin
                o_cmd.sort     = 1'b1;
                o_cmd.scan_run = 1'b1;
            end
            S_EMIT: begin
                o_cmd.sort = 1'b1;
                o_cmd.emit = i_status.out_free;
            end
            S_EMPTY: begin
                o_cmd.emit       = i_status.out_free;
                o_cmd.emit_empty = i_status.out_free;
            end
            default: o_cmd = '0;
        endcase
    end

endmodule

@@ hw/rtl/tks_datapath.sv @@
// ----------------------------------------------------------------------------
// top-k selector datapath
// hit store, distance multiplier, ranking compare and output register
// ----------------------------------------------------------------------------
`include "top_k_result_selector_core_defines.svh"

module tks_datapath #(
    parameter int MAX_KEEP = 32
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  tks_pkg::t_dp_cmd                  i_cmd,
    output tks_pkg::t_dp_status               o_status,
    input  logic [tks_pkg::IN_DATA_W-1:0]     i_in_data,
    input  logic                              i_cfg_wr_en,
    input  logic [tks_pkg::LIMIT_W-1:0]       i_cfg_wr_data,
    input  logic                              i_out_ready,
    output logic                              o_out_valid,
    output logic [tks_pkg::OUT_DATA_W-1:0]    o_out_data,
    output logic                              o_out_last,
    output logic                              o_out_empty
);
    import tks_pkg::*;

    localparam int AW = (MAX_KEEP > 1) ? $clog2(MAX_KEEP) : 1;
    localparam int CW = $clog2(MAX_KEEP + 1);
    localparam int LW = (CW > LIMIT_W) ? CW : LIMIT_W;
    localparam logic [CW-1:0] KEEP_MAX = CW'(MAX_KEEP);

    t_entry r_mem [MAX_KEEP];

    logic [LIMIT_W-1:0]    r_keep_limit;
    logic [HITS_W-1:0]     r_hit_total;
    logic [CW-1:0]         r_kept_total;
    t_entry                r_new;
    logic [DIST_W-1:0]     r_sq_x;
    logic [DIST_W-1:0]     r_sq_z;
    logic [CW-1:0]         r_rd_idx;
    logic                  r_rd_vld;
    logic [AW-1:0]         r_rd_tag;
    t_entry                r_rd_data;
    t_entry                r_sel;
    logic [AW-1:0]         r_sel_idx;
    t_entry                r_first;
    logic [CW-1:0]         r_rank;
    logic                  r_out_valid;
    logic [OUT_DATA_W-1:0] r_out_data;
    logic                  r_out_last;
    logic                  r_out_empty;

    logic [COORD_W-1:0]    abs_x;
    logic [COORD_W-1:0]    abs_z;
    logic [COORD_W-1:0]    mul_op;
    logic [DIST_W-1:0]     mul_prod;
    logic                  scan_more;
    logic                  scan_issue;
    logic [AW-1:0]         scan_base;
    logic                  scan_first;
    t_entry                cmp_a;
    t_entry                cmp_b;
    logic                  scan_pick;
    logic                  new_wins;
    logic                  room;
    logic [CW-1:0]         rank_next;
    logic                  emit_last;
    logic                  out_free;
    logic                  mem_we;
    logic [AW-1:0]         mem_waddr;
    t_entry                mem_wdata;

    // magnitudes of the pending hit, squared one per cycle on a shared multiplier
    assign abs_x    = r_new.coord_x[COORD_W-1] ? (~r_new.coord_x + COORD_W'(1)) : r_new.coord_x;
    assign abs_z    = r_new.coord_z[COORD_W-1] ? (~r_new.coord_z + COORD_W'(1)) : r_new.coord_z;
    assign mul_op   = i_cmd.sq_z ? abs_z : abs_x;
    assign mul_prod = DIST_W'(mul_op) * DIST_W'(mul_op);

    assign scan_more  = r_rd_idx < r_kept_total;
    assign scan_issue = i_cmd.scan_run && scan_more;
    assign scan_base  = i_cmd.sort ? r_rank[AW-1:0] : '0;
    assign scan_first = r_rd_tag == scan_base;

    // sort keeps the best, the add walk keeps the worst
    assign cmp_a     = i_cmd.sort ? r_rd_data : r_sel;
    assign cmp_b     = i_cmd.sort ? r_sel : r_rd_data;
    assign scan_pick = f_better(cmp_a, cmp_b);
    assign new_wins  = f_better(r_new, r_sel);

    assign room      = (LW'(r_kept_total) < LW'(r_keep_limit)) && (r_kept_total < KEEP_MAX);
    assign rank_next = r_rank + CW'(1);
    assign emit_last = rank_next == r_kept_total;
    assign out_free  = !r_out_valid || i_out_ready;

    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = r_sel_idx;
        mem_wdata = r_new;
        if (i_cmd.append && room) begin
            mem_we    = 1'b1;
            mem_waddr = r_kept_total[AW-1:0];
        end else if (i_cmd.replace && new_wins) begin
            mem_we    = 1'b1;
        end else if (i_cmd.emit && !i_cmd.emit_empty) begin
            // swap: the entry at the rank slot moves into the winner's slot
            mem_we    = 1'b1;
            mem_wdata = r_first;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        if (scan_issue) begin
            r_rd_data <= r_mem[r_rd_idx[AW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_keep_limit <= KEEP_LIMIT_RST;
            r_hit_total  <= '0;
            r_kept_total <= '0;
            r_rd_vld     <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_keep_limit <= i_cfg_wr_data;
            end
            if (i_cmd.accept_add) begin
                r_hit_total <= r_hit_total + HITS_W'(1);
            end
            if (i_cmd.append && room) begin
                r_kept_total <= r_kept_total + CW'(1);
            end else if (i_cmd.emit && !i_cmd.emit_empty && emit_last) begin
                r_kept_total <= '0;
            end
            r_rd_vld <= scan_issue;
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept_add) begin
            r_new.coord_x   <= i_in_data[COORD_W-1:0];
            r_new.coord_z   <= i_in_data[2*COORD_W-1:COORD_W];
            r_new.hit_count <= i_in_data[2*COORD_W+COUNT_W-1:2*COORD_W];
        end
        if (i_cmd.sq_x) begin
            r_sq_x <= mul_prod;
        end
        if (i_cmd.sq_z) begin
            r_sq_z <= mul_prod;
        end
        if (i_cmd.sum) begin
            r_new.dist_sq <= r_sq_x + r_sq_z;
        end
        if (i_cmd.accept_fin) begin
            r_rank <= '0;
        end else if (i_cmd.emit && !i_cmd.emit_empty) begin
            r_rank <= rank_next;
        end
        if (i_cmd.scan_start) begin
            r_rd_idx <= i_cmd.sort ? r_rank : '0;
        end else if (scan_issue) begin
            r_rd_idx <= r_rd_idx + CW'(1);
        end
        if (scan_issue) begin
            r_rd_tag <= r_rd_idx[AW-1:0];
        end
        if (r_rd_vld && (scan_first || scan_pick)) begin
            r_sel     <= r_rd_data;
            r_sel_idx <= r_rd_tag;
        end
        if (r_rd_vld && scan_first) begin
            r_first <= r_rd_data;
        end
        if (i_cmd.emit) begin
            if (i_cmd.emit_empty) begin
                r_out_data  <= {OUT_PAD_W'(0), r_hit_total, COUNT_W'(0), COORD_W'(0),
                                COORD_W'(0), RANK_W'(0)};
                r_out_last  <= 1'b1;
                r_out_empty <= 1'b1;
            end else begin
                r_out_data  <= {OUT_PAD_W'(0), r_hit_total, r_sel.hit_count, r_sel.coord_z,
                                r_sel.coord_x, RANK_W'(r_rank)};
                r_out_last  <= emit_last;
                r_out_empty <= 1'b0;
            end
        end
    end

    assign o_status.kept_zero = r_kept_total == '0;
    assign o_status.room      = room;
    assign o_status.scan_done = !scan_more && !r_rd_vld;
    assign o_status.out_free  = out_free;
    assign o_status.emit_last = emit_last;

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;
    assign o_out_last  = r_out_last;
    assign o_out_empty = r_out_empty;

    `TKS_ASSERT_NOW(a_kept_bound, i_clk, i_rst_n, 1'b1, r_kept_total <= KEEP_MAX)
    `TKS_ASSERT_NOW(a_emit_free, i_clk, i_rst_n, i_cmd.emit, out_free)
    `TKS_ASSERT_NEXT(a_hit_count, i_clk, i_rst_n, i_cmd.accept_add, r_hit_total == $past(r_hit_total) + HITS_W'(1))
    `TKS_ASSERT_NEXT(a_finish_clears, i_clk, i_rst_n, i_cmd.emit && !i_cmd.emit_empty && emit_last, r_kept_total == '0)

endmodule

@@ hw/rtl/top_k_result_selector_core.sv @@
// ----------------------------------------------------------------------------
// top-k result selector core
// keeps the best keep_limit (at most MAX_KEEP) search hits and emits them sorted on finish
// ----------------------------------------------------------------------------
// add beat: squares x and z and sums them, then appends the hit while the
//   store has room, else walks the single read port for the worst entry
//   and replaces it if the new hit ranks better; finish beat: selection sort
//   over the same port, one result beat per rank, held by output stalls
// synchronous active-low reset clears the store count, hit total and output
//   valid and sets keep_limit to 32; stored entries are not cleared
// ----------------------------------------------------------------------------
module top_k_result_selector_core #(
    parameter int MAX_KEEP = 32
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // input stream
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // x_coord [31:0], z_coord [63:32], slime_count [71:64]
    input  logic [tks_pkg::IN_DATA_W-1:0]   s_axis_tdata,
    // operation [0]
    input  logic                            s_axis_tuser,
    // result stream
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // rank [4:0], out_x [36:5], out_z [68:37], out_count [76:69],
    // hits_seen [140:77], zero [143:141]
    output logic [tks_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
    // is_last
    output logic                            m_axis_tlast,
    // is_empty [0]
    output logic                            m_axis_tuser,
    // keep_limit register
    input  logic                            i_cfg_wr_en,
    input  logic [tks_pkg::LIMIT_W-1:0]     i_cfg_wr_data
);
    import tks_pkg::*;

    // command and status between sequencer and datapath
    t_dp_cmd    dp_cmd;
    t_dp_status dp_status;

    // controller: one beat in flight at a time, ready only when idle
    tks_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_in_op    (s_axis_tuser),
        .o_in_ready (s_axis_tready),
        .i_status   (dp_status),
        .o_cmd      (dp_cmd)
    );

    // datapath: store, multiplier, compare, output register
    tks_datapath #(
        .MAX_KEEP (MAX_KEEP)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (dp_cmd),
        .o_status      (dp_status),
        .i_in_data     (s_axis_tdata),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_out_ready   (m_axis_tready),
        .o_out_valid   (m_axis_tvalid),
        .o_out_data    (m_axis_tdata),
        .o_out_last    (m_axis_tlast),
        .o_out_empty   (m_axis_tuser)
    );

endmodule
